FILE: sv/pnguf_pkg.sv
package pnguf_pkg;

	localparam int MAX_ROW_BYTES_DEF   = 8192;
	localparam int MAX_PIXEL_BYTES_DEF = 4;

	localparam int ROW_W    = 14;
	localparam int BPP_W    = 3;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	// register map, one 32-bit word per register
	localparam logic REG_ROW_BYTES = 1'b0;
	localparam logic REG_BPP       = 1'b1;

	localparam logic [2:0] FILT_NONE  = 3'd0;
	localparam logic [2:0] FILT_SUB   = 3'd1;
	localparam logic [2:0] FILT_UP    = 3'd2;
	localparam logic [2:0] FILT_AVG   = 3'd3;
	localparam logic [2:0] FILT_PAETH = 3'd4;

	localparam logic [7:0] FILT_MAX_CODE = 8'd4;

	typedef struct packed {
		logic [7:0] data;
		logic       is_filter;
		logic [2:0] filter;
		logic       err;
		logic       first_row;
		logic       last;
	} item_t;

endpackage

FILE: sv/pnguf_in_if.sv
interface pnguf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] filtered_byte;
	logic       frame_start;

	modport source (output valid, filtered_byte, frame_start, input ready);
	modport sink (input valid, filtered_byte, frame_start, output ready);
endinterface

FILE: sv/pnguf_out_if.sv
interface pnguf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;
	logic       row_end;
	logic       bad_filter;

	modport source (output valid, pixel_byte, row_end, bad_filter, input ready);
	modport sink (input valid, pixel_byte, row_end, bad_filter, output ready);
endinterface

FILE: sv/png_scanline_unfilter.sv
// A data byte accepted on din is held in stage one, then registered in the output register before it is shown on dout.
// Throughput: one byte per cycle while dout is not stalled; the line store is read at accept and
// written when the byte leaves stage one, one port each, so no access pattern stalls.
// Filter type bytes produce no transaction and never stall the input.
// Reset (arst_n low, asynchronous) clears control state, registers and neighbor
// slots; the line store is not cleared, the first row ignores what it reads.
module png_scanline_unfilter
	import pnguf_pkg::*;
#(
	parameter int MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
	parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	pnguf_in_if.sink           din,
	pnguf_out_if.source        dout,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int AW = $clog2(MAX_ROW_BYTES);
	localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	logic [ROW_W-1:0] row_bytes_q;
	logic [BPP_W-1:0] bpp_q;

	pnguf_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.row_bytes_q (row_bytes_q),
		.bpp_q       (bpp_q)
	);

	// effective (saturated) row length and pixel size
	logic [ROW_W-1:0] len;
	logic [3:0]       bpp_eff;
	logic [SW-1:0]    bpp_sel;

	always_comb begin
		if (row_bytes_q == '0)                         len = ROW_W'(1);
		else if (32'(row_bytes_q) > MAX_ROW_BYTES)     len = ROW_W'(MAX_ROW_BYTES);
		else                                           len = row_bytes_q;
		if (bpp_q == '0)                               bpp_eff = 4'd1;
		else if ({1'b0, bpp_q} > 4'(MAX_PIXEL_BYTES))  bpp_eff = 4'(MAX_PIXEL_BYTES);
		else                                           bpp_eff = {1'b0, bpp_q};
		bpp_sel = SW'(bpp_eff - 4'd1);
	end

	// row control state
	logic [ROW_W-1:0] column_q;
	logic             first_row_q;
	logic [2:0]       row_filter_q;
	logic             row_error_q;
	// res_q[k]: next data index modulo k+1
	logic [SW-1:0]    res_q [MAX_PIXEL_BYTES];

	// pipeline
	logic          s1_valid_s1;
	item_t         item_s1;
	logic [SW-1:0] slot_s1;
	logic [AW-1:0] addr_s1;
	logic          s1_adv;
	logic          accept;

	logic       out_valid_q;
	logic [7:0] pixel_q;
	logic       row_end_q;
	logic       bad_q;

	logic [ROW_W-1:0] col_a, col_b, idx;
	logic             first_a, first_b, row_over, is_filter, last;
	logic [SW-1:0]    slot;
	item_t            item_a;

	always_comb begin
		col_a    = din.frame_start ? '0 : column_q;
		first_a  = din.frame_start | first_row_q;
		row_over = col_a > len;
		col_b    = row_over ? '0 : col_a;
		first_b  = row_over ? 1'b0 : first_a;
		is_filter = (col_b == '0);
		idx      = col_b - ROW_W'(1);
		last     = (col_b == len);
		slot     = res_q[bpp_sel];

		item_a.data      = din.filtered_byte;
		item_a.is_filter = is_filter;
		item_a.filter    = row_filter_q;
		item_a.err       = row_error_q;
		item_a.first_row = first_b;
		item_a.last      = last;
	end

	assign s1_adv    = s1_valid_s1 & (item_s1.is_filter | ~out_valid_q | dout.ready);
	assign din.ready = ~s1_valid_s1 | s1_adv;
	assign accept    = din.valid & din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			first_row_q  <= 1'b1;
			row_filter_q <= FILT_NONE;
			row_error_q  <= 1'b0;
			for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
				res_q[k] <= '0;
			end
		end else if (accept) begin
			if (is_filter) begin
				column_q    <= ROW_W'(1);
				first_row_q <= first_b;
				if (din.filtered_byte <= FILT_MAX_CODE) begin
					row_filter_q <= din.filtered_byte[2:0];
					row_error_q  <= 1'b0;
				end else begin
					row_filter_q <= FILT_NONE;
					row_error_q  <= 1'b1;
				end
				for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
					res_q[k] <= '0;
				end
			end else begin
				if (last) begin
					column_q    <= '0;
					first_row_q <= 1'b0;
				end else begin
					column_q    <= col_b + ROW_W'(1);
					first_row_q <= first_b;
				end
				for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
					res_q[k] <= (res_q[k] == SW'(k)) ? '0 : res_q[k] + SW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_a;
			slot_s1 <= slot;
			addr_s1 <= AW'(idx);
		end
	end

	logic [7:0] prior;
	logic [7:0] pixel;
	logic       rd_en, wr_en;

	assign rd_en = accept & ~is_filter;
	assign wr_en = s1_adv & ~item_s1.is_filter;

	pnguf_line_store #(
		.DEPTH (MAX_ROW_BYTES),
		.AW    (AW)
	) u_line (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (AW'(idx)),
		.rd_data (prior),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (pixel)
	);

	pnguf_recon #(
		.MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
		.SW              (SW)
	) u_recon (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.slot    (slot_s1),
		.prior   (prior),
		.advance (s1_adv),
		.pixel   (pixel)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr_en) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pixel_q   <= pixel;
			row_end_q <= item_s1.last;
			bad_q     <= item_s1.err;
		end
	end

	assign dout.valid      = out_valid_q;
	assign dout.pixel_byte = pixel_q;
	assign dout.row_end    = row_end_q;
	assign dout.bad_filter = bad_q;

`ifndef SYNTHESIS
	// a row is never reread at an entry still being written back
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (AW'(idx) != addr_s1))
		else $error("line store read and write hit the same entry");

	a_bad_row_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.bad_filter) |-> (dout.pixel_byte == 8'd0))
		else $error("bad filter row produced nonzero byte");

	a_filter_opens_row: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_filter) |=> (column_q == ROW_W'(1)))
		else $error("filter type byte did not open a row");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !item_s1.is_filter && out_valid_q && !dout.ready)
		|=> (s1_valid_s1 && $stable(addr_s1)))
		else $error("stalled data byte left stage one");
`endif

endmodule

FILE: sv/pnguf_apb_regs.sv
module pnguf_apb_regs
	import pnguf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [ROW_W-1:0]   row_bytes_q,
	output logic [BPP_W-1:0]   bpp_q
);

	logic wr;
	logic sel;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;
	assign sel    = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= ROW_W'(1);
			bpp_q       <= BPP_W'(1);
		end else if (wr) begin
			unique case (sel)
				REG_ROW_BYTES: row_bytes_q <= pwdata[ROW_W-1:0];
				REG_BPP:       bpp_q       <= pwdata[BPP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_ROW_BYTES: prdata = PDATA_W'(row_bytes_q);
			REG_BPP:       prdata = PDATA_W'(bpp_q);
			default:       prdata = '0;
		endcase
	end

endmodule

FILE: sv/pnguf_line_store.sv
module pnguf_line_store
	import pnguf_pkg::*;
#(
	parameter int DEPTH = MAX_ROW_BYTES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: sv/pnguf_recon.sv
module pnguf_recon
	import pnguf_pkg::*;
#(
	parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF,
	parameter int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  item_t         item,
	input  logic [SW-1:0] slot,
	input  logic [7:0]    prior,
	input  logic          advance,
	output logic [7:0]    pixel
);

	logic [7:0] left_q [MAX_PIXEL_BYTES];
	logic [7:0] ul_q   [MAX_PIXEL_BYTES];

	logic [7:0]        a, b, c, pred;
	logic [8:0]        avg_sum;
	logic signed [9:0] p, da, db, dc;
	logic [7:0]        paeth;

	assign a = left_q[slot];
	assign c = ul_q[slot];
	assign b = item.first_row ? 8'd0 : prior;

	assign avg_sum = {1'b0, a} + {1'b0, b};

	always_comb begin
		p  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
		da = p - $signed({2'b00, a});
		db = p - $signed({2'b00, b});
		dc = p - $signed({2'b00, c});
		if (da < 0) da = -da;
		if (db < 0) db = -db;
		if (dc < 0) dc = -dc;
		if (da <= db && da <= dc) paeth = a;
		else if (db <= dc)        paeth = b;
		else                      paeth = c;
	end

	always_comb begin
		unique case (item.filter)
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = avg_sum[8:1];
			FILT_PAETH: pred = paeth;
			default:    pred = 8'd0;
		endcase
	end

	assign pixel = item.err ? 8'd0 : item.data + pred;

	// neighbor slots: cleared at each row start, updated per data byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				left_q[i] <= 8'd0;
				ul_q[i]   <= 8'd0;
			end
		end else if (advance) begin
			if (item.is_filter) begin
				for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
					left_q[i] <= 8'd0;
					ul_q[i]   <= 8'd0;
				end
			end else begin
				left_q[slot] <= pixel;
				ul_q[slot]   <= b;
			end
		end
	end

endmodule

FILE: test/tb_png_scanline_unfilter.sv
module tb_png_scanline_unfilter;
	import pnguf_pkg::*;

	localparam int HANG_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 1950;

	typedef struct packed {
		logic [7:0] fbyte;
		logic       fs;
	} stream_item_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       row_end;
		logic       bad;
	} pixel_exp_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	pnguf_in_if  din_if ();
	pnguf_out_if dout_if ();

	png_scanline_unfilter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (din_if),
		.dout    (dout_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	stream_item_t pending[$];
	pixel_exp_t   expected_pixels[$];

	// predictor state, mirrors the block
	logic [7:0]       line_mem [MAX_ROW_BYTES_DEF];
	logic [7:0]       left_px [MAX_PIXEL_BYTES_DEF];
	logic [7:0]       upleft_px [MAX_PIXEL_BYTES_DEF];
	int               cur_col = 0;
	logic [2:0]       cur_filter = FILT_NONE;
	bit               on_top_row = 1'b1;
	bit               row_bad = 1'b0;
	logic [ROW_W-1:0] cfg_row_bytes = 1;
	logic [BPP_W-1:0] cfg_bpp = 1;

	// stimulus-side view of row position, keeps line store reads on written entries
	int plan_col = 0;
	bit plan_first = 1'b1;
	int plan_filled = 0;
	int plan_len = 1;

	int unsigned mismatches = 0;
	int unsigned n_stream = 0;
	int unsigned n_pixels = 0;
	int unsigned n_row_ends = 0;
	int unsigned n_bad = 0;
	int unsigned n_frames = 0;
	int unsigned n_settings = 0;

	int          burst_left = 0;
	int          gap_left = 0;
	logic [15:0] sink_pat = '1;
	logic [6:0]  pat_pos = '0;
	int          stall_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_len(input logic [ROW_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_ROW_BYTES_DEF) return MAX_ROW_BYTES_DEF;
		return v;
	endfunction

	function automatic int eff_bpp(input logic [BPP_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_PIXEL_BYTES_DEF) return MAX_PIXEL_BYTES_DEF;
		return v;
	endfunction

	function automatic void reconstruct_byte(input logic [7:0] fbyte, input logic fs);
		int len, bpp, idx, slot, i;
		int ai, bi, ci, p, pa, pb, pc;
		logic [7:0] a, b, c, pred, x;
		pixel_exp_t r;
		len = eff_len(cfg_row_bytes);
		bpp = eff_bpp(cfg_bpp);
		n_stream++;
		if (fs) begin
			n_frames++;
			on_top_row = 1'b1;
			cur_col = 0;
		end
		// row length lowered below the current position closes the row
		if (cur_col > len) begin
			cur_col = 0;
			on_top_row = 1'b0;
		end
		if (cur_col == 0) begin
			if (fbyte <= FILT_MAX_CODE) begin
				cur_filter = fbyte[2:0];
				row_bad = 1'b0;
			end else begin
				cur_filter = FILT_NONE;
				row_bad = 1'b1;
			end
			for (i = 0; i < MAX_PIXEL_BYTES_DEF; i++) begin
				left_px[i] = 8'h00;
				upleft_px[i] = 8'h00;
			end
			cur_col = 1;
			return;
		end
		idx = cur_col - 1;
		slot = idx % bpp;
		a = left_px[slot];
		c = upleft_px[slot];
		b = on_top_row ? 8'h00 : line_mem[idx];
		ai = a;
		bi = b;
		ci = c;
		case (cur_filter)
			FILT_SUB: pred = a;
			FILT_UP: pred = b;
			FILT_AVG: pred = 8'((ai + bi) / 2);
			FILT_PAETH: begin
				p = ai + bi - ci;
				pa = (p > ai) ? p - ai : ai - p;
				pb = (p > bi) ? p - bi : bi - p;
				pc = (p > ci) ? p - ci : ci - p;
				if (pa <= pb && pa <= pc) pred = a;
				else if (pb <= pc) pred = b;
				else pred = c;
			end
			default: pred = 8'h00;
		endcase
		x = row_bad ? 8'h00 : fbyte + pred;
		left_px[slot] = x;
		upleft_px[slot] = b;
		line_mem[idx] = x;
		r.pixel = x;
		r.row_end = (idx + 1 == len);
		r.bad = row_bad;
		if (r.row_end) begin
			cur_col = 0;
			on_top_row = 1'b0;
		end else begin
			cur_col++;
		end
		expected_pixels.push_back(r);
	endfunction

	function automatic void report(input string field, input int want, input int got);
		mismatches++;
		$error("%s mismatch: expected %0h, got %0h", field, want, got);
	endfunction

	// queue one stream byte; with pick set the byte is drawn to suit its position
	task automatic queue_byte(input bit fs_in, input bit pick, input logic [7:0] b_in);
		int col;
		bit first;
		bit fs;
		logic [7:0] b;
		fs = fs_in;
		col = fs ? 0 : plan_col;
		first = fs ? 1'b1 : plan_first;
		if (col > plan_len) begin
			col = 0;
			first = 1'b0;
		end
		// past the written part of the line store: begin a new image instead
		if (col != 0 && !first && col - 1 >= plan_filled) begin
			fs = 1'b1;
			col = 0;
			first = 1'b1;
		end
		b = b_in;
		if (col == 0) begin
			if (pick) begin
				if ($urandom_range(0, 11) != 0)
					b = 8'($urandom_range(FILT_NONE, FILT_PAETH));
				else
					b = 8'($urandom_range(FILT_MAX_CODE + 1, 255));
			end
			col = 1;
		end else begin
			if (pick) begin
				if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				else b = 8'($urandom);
			end
			if (col > plan_filled) plan_filled = col;
			if (col == plan_len) begin
				col = 0;
				first = 1'b0;
			end else begin
				col++;
			end
		end
		plan_col = col;
		plan_first = first;
		pending.push_back('{fbyte: b, fs: fs});
	endtask

	task automatic reg_write(input logic idx, input logic [PDATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(input logic [ROW_W-1:0] rb, input logic [BPP_W-1:0] bpp);
		logic [PDATA_W-1:0] w;
		w = $urandom;
		w[ROW_W-1:0] = rb;
		reg_write(REG_ROW_BYTES, w);
		w = $urandom;
		w[BPP_W-1:0] = bpp;
		reg_write(REG_BPP, w);
		plan_len = eff_len(rb);
		n_settings++;
		@(negedge clk);
	endtask

	// filter bytes give no transaction, so let the pipe settle past the last result
	task automatic drain();
		while (pending.size() != 0 || din_if.valid || expected_pixels.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stim
		int n, k, random_items;
		bit big, big_done, fs;
		logic [ROW_W-1:0] rb;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		din_if.valid = 1'b0;
		din_if.filtered_byte = 8'h00;
		din_if.frame_start = 1'b0;
		dout_if.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: each filter on two-byte rows, byte extremes, bad codes,
		// an image restart in the middle of a row
		set_config(2, 1);
		queue_byte(1, 0, FILT_SUB);   queue_byte(0, 0, 8'hFF); queue_byte(0, 0, 8'h01);
		queue_byte(0, 0, FILT_UP);    queue_byte(0, 0, 8'h00); queue_byte(0, 0, 8'hFF);
		queue_byte(0, 0, FILT_AVG);   queue_byte(0, 0, 8'hFF); queue_byte(0, 0, 8'h07);
		queue_byte(0, 0, FILT_PAETH); queue_byte(0, 0, 8'h01); queue_byte(0, 0, 8'h80);
		queue_byte(0, 0, FILT_NONE);  queue_byte(0, 0, 8'hFF); queue_byte(0, 0, 8'h00);
		queue_byte(0, 0, 8'(FILT_MAX_CODE + 1)); queue_byte(0, 0, 8'h0C);
		queue_byte(0, 0, 8'h22);
		queue_byte(0, 0, 8'hFF);      queue_byte(0, 0, 8'hC8);
		queue_byte(1, 0, FILT_PAETH); queue_byte(0, 0, 8'h09);
		drain();

		random_items = 0;
		big_done = 1'b0;
		while (random_items < RANDOM_ITEMS) begin
			big = !big_done && random_items > 600;
			if (big) begin
				// a long row with the length register at the limit, left open
				rb = $urandom_range(0, 1) ? 14'd8192 : '1;
				n = $urandom_range(150, 300);
				big_done = 1'b1;
			end else begin
				case ($urandom_range(0, 9))
					0: rb = '0;
					1, 2: rb = 14'($urandom_range(17, 64));
					default: rb = 14'($urandom_range(1, 16));
				endcase
				n = $urandom_range(20, 150);
			end
			set_config(rb, 3'($urandom_range(0, 7)));
			for (k = 0; k < n; k++) begin
				if (k == 0) fs = big || $urandom_range(0, 3) == 0;
				else fs = !big && $urandom_range(0, 99) == 0;
				queue_byte(fs, 1, 8'h00);
			end
			random_items += n;
			drain();
		end

		$display("%0d stream bytes over %0d register settings, %0d image starts",
			n_stream, n_settings, n_frames);
		$display("%0d pixel bytes checked, %0d row ends, %0d from rows with a bad filter",
			n_pixels, n_row_ends, n_bad);
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("** png_scanline_unfilter: PASSED **");
		end else begin
			$display("** png_scanline_unfilter: FAILED **");
		end
		$finish;
	end

	// source: bursts of random length with random gaps
	always @(posedge clk) begin : src_drv
		stream_item_t nxt;
		if (!arst_n) begin
			din_if.valid <= 1'b0;
		end else if (!din_if.valid || din_if.ready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				din_if.valid <= 1'b0;
			end else if (pending.size() != 0) begin
				nxt = pending.pop_front();
				din_if.valid <= 1'b1;
				din_if.filtered_byte <= nxt.fbyte;
				din_if.frame_start <= nxt.fs;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 48);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				din_if.valid <= 1'b0;
			end
		end
	end

	// sink: a 16-bit ready pattern, played in a loop and redrawn each time the 7-bit position wraps
	always @(posedge clk) begin
		if (pat_pos == 0) begin
			case ($urandom_range(0, 3))
				0: sink_pat <= '1;
				1: sink_pat <= 16'($urandom);
				2: sink_pat <= 16'($urandom & $urandom);
				default: sink_pat <= 16'($urandom | $urandom);
			endcase
		end
		dout_if.ready <= sink_pat[pat_pos[3:0]];
		pat_pos <= pat_pos + 1'b1;
	end

	always @(posedge clk) begin : scoreboard
		pixel_exp_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[PADDR_W-1:2] == REG_ROW_BYTES) cfg_row_bytes = pwdata[ROW_W-1:0];
				else if (paddr[PADDR_W-1:2] == REG_BPP) cfg_bpp = pwdata[BPP_W-1:0];
			end
			if (dout_if.valid && dout_if.ready) begin
				n_pixels++;
				if (expected_pixels.size() == 0) begin
					mismatches++;
					$error("pixel transaction with none expected: pixel_byte %0h",
						dout_if.pixel_byte);
				end else begin
					want = expected_pixels.pop_front();
					if (want.row_end) n_row_ends++;
					if (want.bad) n_bad++;
					if (dout_if.pixel_byte !== want.pixel)
						report("pixel_byte", want.pixel, dout_if.pixel_byte);
					if (dout_if.row_end !== want.row_end)
						report("row_end", want.row_end, dout_if.row_end);
					if (dout_if.bad_filter !== want.bad)
						report("bad_filter", want.bad, dout_if.bad_filter);
				end
			end
			if (din_if.valid && din_if.ready)
				reconstruct_byte(din_if.filtered_byte, din_if.frame_start);
		end
	end

	always @(posedge clk) begin
		if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) ||
				(psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= HANG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles, %0d results outstanding",
				HANG_LIMIT, expected_pixels.size());
			$display("** png_scanline_unfilter: FAILED **");
			$finish;
		end
	end

endmodule
